// ===== hdl/ppi_pkg.sv =====
// Package for the particle pool integrator: item kinds, colour table, slot record.
// No dependencies.
package ppi_pkg;

   localparam logic [1:0] KIND_SPAWN = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_READ  = 2'd2;

   typedef struct packed {
      logic signed [31:0] px;
      logic signed [31:0] py;
      logic signed [31:0] pz;
      logic signed [31:0] vx;
      logic signed [31:0] vy;
      logic signed [31:0] vz;
      logic [31:0]        life_left;
      logic [31:0]        life_init;
      logic [7:0]         ptype;
   } slot_type;

   typedef struct packed {
      logic [7:0] r;
      logic [7:0] g;
      logic [7:0] b;
   } colour_type;

   // Map a type code to its colour; unknown codes draw as fire.
   function automatic colour_type type_colour(input logic [7:0] t);
      colour_type c;
      case (t)
         8'd1:    c = '{8'd255, 8'd255, 8'd51};
         8'd2:    c = '{8'd255, 8'd255, 8'd255};
         8'd3:    c = '{8'd77, 8'd128, 8'd255};
         default: c = '{8'd255, 8'd102, 8'd26};
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/ppi_mover.sv =====
// Position update for one coordinate: pos + floor(vel*step/2^16), saturated.
// One register stage on the product; shift, add and clamp follow it. Depends on nothing.
module ppi_mover (
   input  logic               clock,
   input  logic signed [31:0] pos,
   input  logic signed [31:0] vel,
   input  logic [31:0]        step,
   output logic signed [31:0] result
);
   logic signed [64:0] prod_ff;
   logic signed [31:0] pos_ff;
   logic signed [49:0] delta;
   logic signed [50:0] sum;

   // Stage 1: signed by unsigned product.
   always_ff @(posedge clock) begin
      prod_ff <= 65'(vel * $signed({1'b0, step}));
      pos_ff  <= pos;
   end

   // Stage 2: arithmetic shift (floor), add and clamp.
   assign delta = 50'(prod_ff >>> 16);
   assign sum = 51'(delta) + 51'(pos_ff);

   always_comb begin
      if (sum > 51'sh0_7FFF_FFFF) begin
         result = 32'sh7FFF_FFFF;
      end else if (sum < -51'sh8000_0000) begin
         result = 32'sh8000_0000;
      end else begin
         result = sum[31:0];
      end
   end
endmodule

// ===== hdl/ppi_divider.sv =====
// Restoring divider for alpha: (left << 16) / init, saturated to 16 bits.
// One quotient bit per cycle. Depends on nothing.
module ppi_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [15:0] quot
);
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [47:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [47:0] q_ff, q_in;
   logic [31:0] den_ff;
   logic [32:0] shifted;

   assign shifted = {rem_ff[31:0], dvd_ff[47]};

   always_comb begin
      cnt_in = cnt_ff; busy_in = busy_ff; dvd_in = dvd_ff; rem_in = rem_ff; q_in = q_ff;
      done = 1'b0;
      if (start) begin
         busy_in = 1'b1; cnt_in = 6'd0; dvd_in = {num, 16'd0}; rem_in = '0; q_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[46:0], 1'b0};
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = shifted - {1'b0, den_ff}; q_in = {q_ff[46:0], 1'b1};
         end else begin
            rem_in = shifted; q_in = {q_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd47) begin
            busy_in = 1'b0;
         end
      end else if (cnt_ff == 6'd48) begin
         done = 1'b1; cnt_in = 6'd0;
      end
   end

   assign quot = (q_ff[47:16] != 32'd0) ? 16'hFFFF : q_ff[15:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; cnt_ff <= 6'd0;
      end else begin
         busy_ff <= busy_in; cnt_ff <= cnt_in;
      end
      dvd_ff <= dvd_in; rem_ff <= rem_in; q_ff <= q_in;
      if (start) begin
         den_ff <= den;
      end
   end
endmodule

// ===== hdl/particle_pool_integrator.sv =====
// Top level of the particle pool integrator: slot memory, sweep sequencer, result word.
// Uses ppi_pkg, ppi_mover and ppi_divider.
//
//  channel | direction | handshake
//  req_*   | in        | req_valid / req_ready
//  rsp_*   | out       | rsp_valid / rsp_ready
//
// Spawn: one live flag compare per cycle, then a memory write.
// Tick: a live slot takes read, compare, product and write-back.
// Read: a live slot with nonzero initial life goes through the bit-serial alpha
// divider; other reads skip it.
// Reset clears the live flags at once; slot contents stay undefined until spawned.
// A waiting result word holds in the output register; the next word is accepted meanwhile.
module particle_pool_integrator #(
   parameter int SLOTS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic signed [31:0] req_vel_x,
   input  logic signed [31:0] req_vel_y,
   input  logic signed [31:0] req_vel_z,
   input  logic [31:0]        req_lifetime,
   input  logic [7:0]         req_particle_type,
   input  logic [31:0]        req_time_step,
   input  logic [5:0]         req_slot_select,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [5:0]         rsp_slot_out,
   output logic               rsp_accepted,
   output logic               rsp_slot_active,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic [7:0]         rsp_red,
   output logic [7:0]         rsp_green,
   output logic [7:0]         rsp_blue,
   output logic [15:0]        rsp_alpha
);
   import ppi_pkg::*;

   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = AW + 1;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_SCAN = 4'd1;
   localparam logic [3:0] ST_TRD  = 4'd2;
   localparam logic [3:0] ST_TWT  = 4'd3;
   localparam logic [3:0] ST_TM1  = 4'd4;
   localparam logic [3:0] ST_TM2  = 4'd5;
   localparam logic [3:0] ST_RRD  = 4'd6;
   localparam logic [3:0] ST_RWT  = 4'd7;
   localparam logic [3:0] ST_RDIV = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;

   // Slot memory with registered read.
   slot_type mem [SLOTS];
   slot_type rd_ff;
   logic [SLOTS-1:0] live_ff, live_in;

   logic [3:0] state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   slot_type spawn_ff;
   logic [31:0] step_ff;
   logic [5:0] sel_ff;

   logic rd_en, wr_en;
   logic [AW-1:0] rd_addr, wr_addr;
   slot_type wr_data;

   logic        out_full_ff, out_full_in;
   logic [5:0]  o_slot_ff, o_slot_in;
   logic        o_acc_ff, o_acc_in, o_act_ff, o_act_in;
   logic [31:0] o_x_ff, o_x_in, o_y_ff, o_y_in, o_z_ff, o_z_in;
   colour_type  o_col_ff, o_col_in;
   logic [15:0] o_alpha_ff, o_alpha_in;

   logic signed [31:0] nx, ny, nz;
   logic div_start, div_done;
   logic [15:0] div_q;
   logic accept;

   ppi_mover u_mx (.clock, .pos(rd_ff.px), .vel(rd_ff.vx), .step(step_ff), .result(nx));
   ppi_mover u_my (.clock, .pos(rd_ff.py), .vel(rd_ff.vy), .step(step_ff), .result(ny));
   ppi_mover u_mz (.clock, .pos(rd_ff.pz), .vel(rd_ff.vz), .step(step_ff), .result(nz));

   ppi_divider u_div (
      .clock, .reset, .start(div_start),
      .num(rd_ff.life_left), .den(rd_ff.life_init), .done(div_done), .quot(div_q)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;

   // Memory port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff; idx_in = idx_ff; live_in = live_ff;
      rd_en = 1'b0; rd_addr = idx_ff[AW-1:0];
      wr_en = 1'b0; wr_addr = idx_ff[AW-1:0]; wr_data = rd_ff;
      div_start = 1'b0;
      out_full_in = out_full_ff;
      o_slot_in = o_slot_ff; o_acc_in = o_acc_ff; o_act_in = o_act_ff;
      o_x_in = o_x_ff; o_y_in = o_y_ff; o_z_in = o_z_ff;
      o_col_in = o_col_ff; o_alpha_in = o_alpha_ff;
      if (out_full_ff && rsp_ready) begin
         out_full_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in = '0;
               case (req_kind)
                  KIND_SPAWN: state_in = ST_SCAN;
                  KIND_TICK:  state_in = (req_time_step == 32'd0) ? ST_DONE : ST_TRD;
                  KIND_READ:  state_in = ST_RRD;
                  default:    state_in = ST_DONE;
               endcase
               // Preload the result word for tick and unused kinds.
               o_slot_in = '0; o_acc_in = 1'b1; o_act_in = 1'b0;
               o_x_in = '0; o_y_in = '0; o_z_in = '0; o_col_in = '0; o_alpha_in = '0;
            end
         end
         // Scan live flags for the lowest free slot.
         ST_SCAN: begin
            if (idx_ff == CW'(SLOTS)) begin
               o_acc_in = 1'b0; state_in = ST_DONE;
            end else if (!live_ff[idx_ff[AW-1:0]]) begin
               wr_en = 1'b1; wr_data = spawn_ff;
               live_in[idx_ff[AW-1:0]] = 1'b1;
               o_slot_in = 6'(idx_ff); state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end
         // Tick sweep: read, compare, product, write back; an expired slot is freed.
         ST_TRD: begin
            if (idx_ff == CW'(SLOTS)) begin
               state_in = ST_DONE;
            end else if (!live_ff[idx_ff[AW-1:0]]) begin
               idx_in = idx_ff + CW'(1);
            end else begin
               rd_en = 1'b1; state_in = ST_TWT;
            end
         end
         ST_TWT: begin
            if (step_ff >= rd_ff.life_left) begin
               live_in[idx_ff[AW-1:0]] = 1'b0;
               idx_in = idx_ff + CW'(1); state_in = ST_TRD;
            end else begin
               state_in = ST_TM1;
            end
         end
         ST_TM1: state_in = ST_TM2;
         ST_TM2: begin
            wr_en = 1'b1;
            wr_data.px = nx; wr_data.py = ny; wr_data.pz = nz;
            wr_data.life_left = rd_ff.life_left - step_ff;
            idx_in = idx_ff + CW'(1); state_in = ST_TRD;
         end
         // Read a slot.
         ST_RRD: begin
            o_slot_in = sel_ff;
            if ((int'(sel_ff) < SLOTS) && live_ff[AW'(sel_ff)]) begin
               rd_en = 1'b1; rd_addr = AW'(sel_ff); state_in = ST_RWT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_RWT: begin
            o_act_in = 1'b1;
            o_x_in = rd_ff.px; o_y_in = rd_ff.py; o_z_in = rd_ff.pz;
            o_col_in = type_colour(rd_ff.ptype);
            if (rd_ff.life_init == 32'd0) begin
               state_in = ST_DONE;
            end else begin
               div_start = 1'b1; state_in = ST_RDIV;
            end
         end
         ST_RDIV: begin
            if (div_done) begin
               o_alpha_in = div_q; state_in = ST_DONE;
            end
         end
         // Hand the result word to the output register.
         ST_DONE: begin
            if (!out_full_ff || rsp_ready) begin
               out_full_in = 1'b1; state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result registers hold the finished word; working copies live in o_*_ff
   // until ST_DONE, so output ports show the snapshot below.
   logic [5:0]  r_slot_ff;
   logic        r_acc_ff, r_act_ff;
   logic [31:0] r_x_ff, r_y_ff, r_z_ff;
   colour_type  r_col_ff;
   logic [15:0] r_alpha_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; live_ff <= '0; out_full_ff <= 1'b0; idx_ff <= '0;
      end else begin
         state_ff <= state_in; live_ff <= live_in; out_full_ff <= out_full_in;
         idx_ff <= idx_in;
      end
      o_slot_ff <= o_slot_in; o_acc_ff <= o_acc_in; o_act_ff <= o_act_in;
      o_x_ff <= o_x_in; o_y_ff <= o_y_in; o_z_ff <= o_z_in;
      o_col_ff <= o_col_in; o_alpha_ff <= o_alpha_in;
      if (state_ff == ST_DONE && (!out_full_ff || rsp_ready)) begin
         r_slot_ff <= o_slot_ff; r_acc_ff <= o_acc_ff; r_act_ff <= o_act_ff;
         r_x_ff <= o_x_ff; r_y_ff <= o_y_ff; r_z_ff <= o_z_ff;
         r_col_ff <= o_col_ff; r_alpha_ff <= o_alpha_ff;
      end
      if (accept) begin
         step_ff <= req_time_step; sel_ff <= req_slot_select;
         spawn_ff <= '{req_pos_x, req_pos_y, req_pos_z, req_vel_x, req_vel_y, req_vel_z,
                       req_lifetime, req_lifetime, req_particle_type};
      end
   end

   assign rsp_valid = out_full_ff;
   assign rsp_slot_out = r_slot_ff;
   assign rsp_accepted = r_acc_ff;
   assign rsp_slot_active = r_act_ff;
   assign rsp_out_x = r_x_ff;
   assign rsp_out_y = r_y_ff;
   assign rsp_out_z = r_z_ff;
   assign rsp_red = r_col_ff.r;
   assign rsp_green = r_col_ff.g;
   assign rsp_blue = r_col_ff.b;
   assign rsp_alpha = r_alpha_ff;
endmodule
